### hw/rtl/bgra2nv_pkg.sv
// ----------------------------------------------------------------------------
// bgra2nv_pkg
// Shared types, constants and helpers for the BGRA to NV12 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package bgra2nv_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 2048;
  localparam int STORE_DEPTH = MAX_WIDTH / 2;

  localparam int SIZE_W  = 12;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int SLOT_W  = $clog2(STORE_DEPTH);
  localparam int TERM_W  = 9;
  localparam int PAIR_W  = 2 * TERM_W;
  localparam int INDEX_W = 2;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 12'd1920;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 12'd1080;
  localparam logic [SIZE_W-1:0] SIZE_MIN     = 12'd2;

  localparam logic [INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic KIND_LUMA   = 1'b0;
  localparam logic KIND_CHROMA = 1'b1;

  typedef struct packed {
    logic [7:0]        luma;
    logic [TERM_W-1:0] u;
    logic [TERM_W-1:0] v;
  } pixel_terms_t;

  function automatic logic [SIZE_W-1:0] fit_size(input logic [SIZE_W-1:0] value,
                                                 input logic [SIZE_W:0]   limit);
    logic [SIZE_W:0] even;
    logic [SIZE_W:0] lim_even;
    logic [SIZE_W:0] res;
    even     = {1'b0, value[SIZE_W-1:1], 1'b0};
    lim_even = {limit[SIZE_W:1], 1'b0};
    res      = even;
    if (even < {1'b0, SIZE_MIN}) begin
      res = {1'b0, SIZE_MIN};
    end
    if (even > limit) begin
      res = lim_even;
    end
    return res[SIZE_W-1:0];
  endfunction

  function automatic logic [7:0] clamp_byte(input logic [TERM_W-1:0] value);
    return (value > 9'd255) ? 8'd255 : value[7:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/bgra_to_nv12_converter_unit.sv
// ----------------------------------------------------------------------------
// bgra_to_nv12_converter_unit
// BGRA raster pixels in, NV12 luma bytes and 4:2:0 chroma pairs out.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | in_blue, in_green, in_red
//  out     | out_valid / out_stall| out_sample_kind, out_first_byte, out_second_byte,
//          |                      | out_run_last, out_frame_end
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  A pixel passes one input register and one result register.
//  One pixel per cycle while the output does not stall, except a pixel on an odd
//  row and odd column, which yields a luma and then a chroma result on the
//  single result port and holds the input until the chroma pair is out.
//  Synchronous active-low reset; the line store is not cleared, each frame
//  fills it on even rows before odd rows read it. Output stall backs up into
//  in_stall through the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module bgra_to_nv12_converter_unit import bgra2nv_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_blue,
  input  wire logic [7:0]         in_green,
  input  wire logic [7:0]         in_red,

  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_sample_kind,
  output logic [7:0]              out_first_byte,
  output logic [7:0]              out_second_byte,
  output logic                    out_run_last,
  output logic                    out_frame_end,

  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [INDEX_W-1:0] cfg_index,
  input  wire logic [SIZE_W-1:0]  cfg_data
);

  logic [SIZE_W-1:0] width_r, height_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              last_nxt;
  logic              in_accept, cfg_write, s1_move, out_free;

  logic              s1_valid_r;
  logic [7:0]        s1_blue_r, s1_green_r, s1_red_r;
  logic              s1_odd_col_r, s1_odd_row_r, s1_last_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic [PAIR_W-1:0] store_rd_r;
  logic [PAIR_W-1:0] left_r;

  logic [PAIR_W-1:0] line_store [STORE_DEPTH];
  logic              store_we;
  logic [PAIR_W-1:0] store_wd;

  pixel_terms_t      terms;
  logic [TERM_W:0]   pu, pv;
  logic [TERM_W+1:0] su, sv;
  logic [TERM_W+1:0] cb_round, cr_round;
  logic [7:0]        cb, cr;
  logic              chroma_out;

  logic              out_valid_r, out_kind_r, out_last_r, out_end_r;
  logic [7:0]        out_first_r, out_second_r;
  logic              pend_valid_r, pend_end_r;
  logic [7:0]        pend_cb_r, pend_cr_r;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_move   = s1_valid_r && out_free && !pend_valid_r;
  assign in_stall  = s1_valid_r && !s1_move;
  assign in_accept = in_valid && !in_stall;

  // advance raster position
  always_comb begin
    col_nxt  = col_r + COL_W'(1);
    row_nxt  = row_r;
    last_nxt = 1'b0;
    if ({1'b0, col_r} + 12'd1 >= width_r) begin
      col_nxt = '0;
      row_nxt = row_r + ROW_W'(1);
      if ({1'b0, row_r} + 12'd1 >= height_r) begin
        row_nxt  = '0;
        last_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= fit_size(WIDTH_RESET, (SIZE_W+1)'(MAX_WIDTH));
      height_r <= fit_size(HEIGHT_RESET, (SIZE_W+1)'(MAX_HEIGHT));
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_write) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        width_r <= fit_size(cfg_data, (SIZE_W+1)'(MAX_WIDTH));
        col_r   <= '0;
        row_r   <= '0;
      end else if (cfg_index == REG_FRAME_HEIGHT) begin
        height_r <= fit_size(cfg_data, (SIZE_W+1)'(MAX_HEIGHT));
        col_r    <= '0;
        row_r    <= '0;
      end
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_blue_r    <= in_blue;
      s1_green_r   <= in_green;
      s1_red_r     <= in_red;
      s1_odd_col_r <= col_r[0];
      s1_odd_row_r <= row_r[0];
      s1_slot_r    <= col_r[COL_W-1:1];
      s1_last_r    <= last_nxt;
    end
  end

  // line store of even-row pair sums
  always_ff @(posedge clk) begin
    if (in_accept) begin
      store_rd_r <= line_store[col_r[COL_W-1:1]];
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      line_store[s1_slot_r] <= store_wd;
    end
  end

  bgra2nv_math u_math (
    .blue  (s1_blue_r),
    .green (s1_green_r),
    .red   (s1_red_r),
    .terms (terms)
  );

  always_comb begin
    pu       = {1'b0, left_r[TERM_W-1:0]} + {1'b0, terms.u};
    pv       = {1'b0, left_r[PAIR_W-1:TERM_W]} + {1'b0, terms.v};
    su       = {2'b0, store_rd_r[TERM_W-1:0]} + {1'b0, pu};
    sv       = {2'b0, store_rd_r[PAIR_W-1:TERM_W]} + {1'b0, pv};
    cb_round = su + 11'd2;
    cr_round = sv + 11'd2;
    cb       = clamp_byte(cb_round[TERM_W+1:2]);
    cr       = clamp_byte(cr_round[TERM_W+1:2]);
    store_we   = s1_move && s1_odd_col_r && !s1_odd_row_r;
    store_wd   = {pv[TERM_W-1:0], pu[TERM_W-1:0]};
    chroma_out = s1_odd_col_r && s1_odd_row_r;
  end

  // left pixel of the current pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (cfg_write && (cfg_index == REG_FRAME_WIDTH ||
                               cfg_index == REG_FRAME_HEIGHT)) begin
      left_r <= '0;
    end else if (s1_move && !s1_odd_col_r) begin
      left_r <= {terms.v, terms.u};
    end
  end

  // result register and held chroma pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (out_free) begin
      if (pend_valid_r) begin
        out_valid_r  <= 1'b1;
        pend_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= s1_valid_r;
        pend_valid_r <= s1_valid_r && chroma_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_valid_r) begin
        out_kind_r   <= KIND_CHROMA;
        out_first_r  <= pend_cb_r;
        out_second_r <= pend_cr_r;
        out_last_r   <= 1'b1;
        out_end_r    <= pend_end_r;
      end else if (s1_valid_r) begin
        out_kind_r   <= KIND_LUMA;
        out_first_r  <= terms.luma;
        out_second_r <= 8'd0;
        out_last_r   <= !chroma_out;
        out_end_r    <= !chroma_out && s1_last_r;
        pend_cb_r    <= cb;
        pend_cr_r    <= cr;
        pend_end_r   <= s1_last_r;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample_kind = out_kind_r;
  assign out_first_byte  = out_first_r;
  assign out_second_byte = out_second_r;
  assign out_run_last    = out_last_r;
  assign out_frame_end   = out_end_r;

  a_pend_behind_luma: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (out_valid_r && out_kind_r == KIND_LUMA && !out_last_r))
    else $error("held chroma pair without its luma result in front");

  a_chroma_closes_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_CHROMA) |-> out_last_r)
    else $error("chroma pair not marked as last result of its pixel");

  a_frame_end_on_chroma: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_end_r) |-> (out_kind_r == KIND_CHROMA))
    else $error("frame end marked on a luma result");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && (pend_valid_r || (out_valid_r && out_stall))))
    else $error("input stalled with no result backing up");

endmodule

`default_nettype wire

### hw/rtl/bgra2nv_math.sv
// ----------------------------------------------------------------------------
// bgra2nv_math
// BT.601 studio-range luma and per-pixel Cb/Cr terms for one BGRA pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module bgra2nv_math import bgra2nv_pkg::*; (
  input  wire logic [7:0]   blue,
  input  wire logic [7:0]   green,
  input  wire logic [7:0]   red,
  output pixel_terms_t      terms
);

  logic [16:0] b_x, g_x, r_x;
  logic [16:0] y_sum;
  logic [16:0] u_sum;
  logic [16:0] v_sum;
  logic [8:0]  y_val;

  assign b_x = {9'd0, blue};
  assign g_x = {9'd0, green};
  assign r_x = {9'd0, red};

  assign y_sum = 17'd66 * r_x + 17'd129 * g_x + 17'd25 * b_x + 17'd128;
  assign u_sum = 17'd112 * b_x + 17'd32896 - 17'd38 * r_x - 17'd74 * g_x;
  assign v_sum = 17'd112 * r_x + 17'd32896 - 17'd94 * g_x - 17'd18 * b_x;

  assign y_val = {1'b0, y_sum[15:8]} + 9'd16;

  assign terms.luma = clamp_byte(y_val);
  assign terms.u    = u_sum[16:8];
  assign terms.v    = v_sum[16:8];

endmodule

`default_nettype wire

### tb/tb_bgra_to_nv12_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bgra_to_nv12_converter_unit
// Streams BGRA pixels through the converter under several frame sizes and
// predicts every luma byte and every 4:2:0 chroma pair, with its run and
// frame-end marks. Each result is checked against the oldest prediction.
// Both sides insert random gaps.
// ----------------------------------------------------------------------------
module tb_bgra_to_nv12_converter_unit import bgra2nv_pkg::*; ();

  localparam int RANDOM_PIXELS  = 820;
  localparam int LIMIT_PIXELS   = 64;
  localparam int CALM_START     = 200;
  localparam int CALM_PIXELS    = 250;
  localparam int HOLD_CYCLES    = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int GAP_PERCENT    = 38;

  localparam logic [INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic       sample_kind;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       run_last;
    logic       frame_end;
  } nv12_sample_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_blue = '0;
  logic [7:0]         in_green = '0;
  logic [7:0]         in_red = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_sample_kind;
  logic [7:0]         out_first_byte;
  logic [7:0]         out_second_byte;
  logic               out_run_last;
  logic               out_frame_end;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [INDEX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0]  cfg_data = '0;

  bgra_to_nv12_converter_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Converter state as predicted
  int          frame_w;
  int          frame_h;
  int          col_pos;
  int          row_pos;
  logic [8:0]  left_u;
  logic [8:0]  left_v;
  logic [8:0]  pair_u_store [STORE_DEPTH];
  logic [8:0]  pair_v_store [STORE_DEPTH];

  nv12_sample_t pending_samples [$];
  int           mismatch_count = 0;
  int           quiet_cycles = 0;
  bit           gaps_enabled = 1'b1;

  function automatic int size_fit(logic [SIZE_W-1:0] value, int limit);
    int even;
    even = int'(value) & ~1;
    if (even < 2) even = 2;
    if (even > limit) even = limit & ~1;
    return even;
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    left_u  = '0;
    left_v  = '0;
  endfunction

  function automatic void apply_reg(logic [INDEX_W-1:0] idx, logic [SIZE_W-1:0] data);
    if (idx == REG_FRAME_WIDTH) begin
      frame_w = size_fit(data, MAX_WIDTH);
      restart_frame();
    end else if (idx == REG_FRAME_HEIGHT) begin
      frame_h = size_fit(data, MAX_HEIGHT);
      restart_frame();
    end
  endfunction

  function automatic int clamp_255(int value);
    return (value > 255) ? 255 : value;
  endfunction

  function automatic void enqueue_sample(nv12_sample_t sample);
    pending_samples = {pending_samples, sample};
  endfunction

  function automatic void convert_pixel(logic [7:0] b8, logic [7:0] g8, logic [7:0] r8);
    int b, g, r, luma, u, v, pu, pv, su, sv, cb, cr, slot;
    logic chroma, last;
    b = int'(b8);
    g = int'(g8);
    r = int'(r8);
    chroma = 1'b0;
    last = 1'b0;
    cb = 0;
    cr = 0;
    luma = clamp_255(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16);
    u = ((-38 * r - 74 * g + 112 * b + 128) >>> 8) + 128;
    v = ((112 * r - 94 * g - 18 * b + 128) >>> 8) + 128;
    if (col_pos % 2 == 0) begin
      left_u = u[8:0];
      left_v = v[8:0];
    end else begin
      pu = int'(left_u) + u;
      pv = int'(left_v) + v;
      slot = (col_pos / 2) % STORE_DEPTH;
      if (row_pos % 2 == 0) begin
        pair_u_store[slot] = pu[8:0];
        pair_v_store[slot] = pv[8:0];
      end else begin
        su = int'(pair_u_store[slot]) + pu;
        sv = int'(pair_v_store[slot]) + pv;
        cb = clamp_255((su + 2) >>> 2);
        cr = clamp_255((sv + 2) >>> 2);
        chroma = 1'b1;
      end
    end
    col_pos++;
    if (col_pos >= frame_w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= frame_h) begin
        row_pos = 0;
        last = 1'b1;
      end
    end
    enqueue_sample('{KIND_LUMA, luma[7:0], 8'd0, ~chroma, ~chroma & last});
    if (chroma) enqueue_sample('{KIND_CHROMA, cb[7:0], cr[7:0], 1'b1, last});
  endfunction

  function automatic string sample_text(nv12_sample_t s);
    return $sformatf("kind=%0d first=%0d second=%0d last=%0d end=%0d", s.sample_kind,
                     s.first_byte, s.second_byte, s.run_last, s.frame_end);
  endfunction

  function automatic void report_mismatch(nv12_sample_t want, nv12_sample_t got, bit orphan);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      if (orphan)
        $display("%0t: unexpected result %s", $time, sample_text(got));
      else
        $display("%0t: expected %s, got %s", $time, sample_text(want), sample_text(got));
    end
  endfunction

  always @(posedge clk) begin
    nv12_sample_t got;
    nv12_sample_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_sample_kind, out_first_byte, out_second_byte, out_run_last, out_frame_end};
      if (pending_samples.size() == 0) begin
        report_mismatch('0, got, 1'b1);
      end else begin
        want = pending_samples.pop_front();
        if (got !== want) report_mismatch(want, got, 1'b0);
      end
    end
  end

  always @(negedge clk) begin
    out_stall = rst_n && gaps_enabled && ($urandom_range(99) < GAP_PERCENT);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    @(negedge clk);
    while (gaps_enabled && $urandom_range(99) < GAP_PERCENT) begin
      in_valid = 1'b0;
      in_blue  = 8'($urandom);
      in_green = 8'($urandom);
      in_red   = 8'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_blue  = b;
    in_green = g;
    in_red   = r;
    // hold the request until accepted
    do @(posedge clk); while (in_stall);
    convert_pixel(b, g, r);
  endtask

  function automatic logic [7:0] random_component();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random_pixels(int count);
    for (int k = 0; k < count; k++) begin
      send_pixel(random_component(), random_component(), random_component());
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (HOLD_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [INDEX_W-1:0] idx, logic [SIZE_W-1:0] data);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_index = 2'($urandom);
    cfg_data  = 12'($urandom);
  endtask

  task automatic test_reset_size();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd12, 8'd200, 8'd77);
    send_pixel(8'd255, 8'd0, 8'd128);
  endtask

  task automatic test_extreme_pixels();
    write_reg(REG_FRAME_WIDTH, 12'd2);
    write_reg(REG_FRAME_HEIGHT, 12'd2);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
  endtask

  task automatic test_spare_index();
    write_reg(REG_FRAME_WIDTH, 12'd5);
    write_reg(REG_FRAME_HEIGHT, 12'd3);
    send_random_pixels(3);
    // unknown registers must neither resize nor restart the frame
    write_reg(REG_SPARE_2, 12'd6);
    write_reg(REG_SPARE_3, 12'hFFF);
    send_random_pixels(5);
  endtask

  task automatic test_size_limits();
    write_reg(REG_FRAME_WIDTH, 12'd1);
    write_reg(REG_FRAME_HEIGHT, 12'd0);
    send_random_pixels(frame_w * frame_h);
    write_reg(REG_FRAME_WIDTH, 12'd2);
    write_reg(REG_FRAME_HEIGHT, 12'hFFF);
    send_random_pixels(LIMIT_PIXELS);
    write_reg(REG_FRAME_WIDTH, 12'd2050);
    write_reg(REG_FRAME_HEIGHT, 12'd3);
    send_random_pixels(LIMIT_PIXELS);
  endtask

  task automatic test_random_frames();
    int sent;
    int total;
    int calm_sent;
    sent = 0;
    calm_sent = 0;
    while (sent < RANDOM_PIXELS) begin
      gaps_enabled = !(sent >= CALM_START && calm_sent < CALM_PIXELS);
      write_reg(REG_FRAME_WIDTH, 12'($urandom_range(40)));
      write_reg(REG_FRAME_HEIGHT, 12'($urandom_range(12)));
      total = frame_w * frame_h;
      // drop out mid-frame now and then; the next write restarts it
      if ($urandom_range(9) == 0) total = int'($urandom_range(total));
      send_random_pixels(total);
      sent += total;
      if (!gaps_enabled) calm_sent += total;
    end
    gaps_enabled = 1'b1;
  endtask

  initial begin
    frame_w = size_fit(WIDTH_RESET, MAX_WIDTH);
    frame_h = size_fit(HEIGHT_RESET, MAX_HEIGHT);
    restart_frame();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_reset_size();
    test_extreme_pixels();
    test_spare_index();
    test_size_limits();
    test_random_frames();

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_samples.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### bgra_to_nv12_converter_unit.f
hw/rtl/bgra2nv_pkg.sv
hw/rtl/bgra2nv_math.sv
hw/rtl/bgra_to_nv12_converter_unit.sv
tb/tb_bgra_to_nv12_converter_unit.sv
